FILE: hdl/bmc_pkg.sv
// Shared types and constants of the button multi-click classifier.
// No dependencies; imported by every module in hdl/.
package bmc_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned LIMIT_W   = 16;
    localparam int unsigned TARGET_W  = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAPID_GAP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAPID_TARGET  = 3'd4;

    localparam logic [LIMIT_W-1:0]  RST_DOUBLE_WINDOW = 16'd500;
    localparam logic [LIMIT_W-1:0]  RST_SHORT_LIMIT   = 16'd1500;
    localparam logic [LIMIT_W-1:0]  RST_LONG_LIMIT    = 16'd5000;
    localparam logic [LIMIT_W-1:0]  RST_RAPID_GAP     = 16'd500;
    localparam logic [TARGET_W-1:0] RST_RAPID_TARGET  = 3'd5;

    localparam logic [TARGET_W-1:0] RAPID_MAX = 3'd7;

    typedef struct packed {
        logic [LIMIT_W-1:0]  double_window;
        logic [LIMIT_W-1:0]  short_limit;
        logic [LIMIT_W-1:0]  long_limit;
        logic [LIMIT_W-1:0]  rapid_gap;
        logic [TARGET_W-1:0] rapid_target;
    } t_cfg;

    typedef struct packed {
        logic long_hold;
        logic rapid_toggle;
        logic double_click;
        logic single_click;
    } t_evt;

endpackage

FILE: hdl/bmc_cfg.sv
// Configuration register file of the classifier.
// Depends on bmc_pkg for register indexes, reset values and t_cfg.
module bmc_cfg
    import bmc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [LIMIT_W-1:0]   i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.double_window <= RST_DOUBLE_WINDOW;
            r_cfg.short_limit   <= RST_SHORT_LIMIT;
            r_cfg.long_limit    <= RST_LONG_LIMIT;
            r_cfg.rapid_gap     <= RST_RAPID_GAP;
            r_cfg.rapid_target  <= RST_RAPID_TARGET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DOUBLE_WINDOW: r_cfg.double_window <= i_cfg_wdata;
                CFG_SHORT_LIMIT:   r_cfg.short_limit   <= i_cfg_wdata;
                CFG_LONG_LIMIT:    r_cfg.long_limit    <= i_cfg_wdata;
                CFG_RAPID_GAP:     r_cfg.rapid_gap     <= i_cfg_wdata;
                CFG_RAPID_TARGET:  r_cfg.rapid_target  <= i_cfg_wdata[TARGET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/bmc_core.sv
// Classifier state and per-sample decision logic.
// Depends on bmc_pkg; state advances only when i_step is high.
module bmc_core
    import bmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_level,
    input  logic [TIME_W-1:0] i_now,
    input  t_cfg              i_cfg,
    output t_evt              o_evt
);

    logic                r_prev_level;
    logic [TIME_W-1:0]   r_press_start;
    logic [TARGET_W-1:0] r_rapid_count;
    logic [TIME_W-1:0]   r_last_rapid;
    logic                r_click_pend;
    logic [TIME_W-1:0]   r_first_click;
    logic                r_long_rep;

    logic [TIME_W-1:0]   dur;
    logic [TIME_W-1:0]   gap_rapid;
    logic [TIME_W-1:0]   gap_first;
    logic                press;
    logic                release_edge;
    logic                click;
    logic [TARGET_W-1:0] rc_inc;
    logic                tog;
    logic                dbl;
    logic                sgl;
    logic                lng;

    assign dur       = i_now - r_press_start;
    assign gap_rapid = i_now - r_last_rapid;
    assign gap_first = i_now - r_first_click;

    assign press        = (i_level != r_prev_level) && !i_level;
    assign release_edge = (i_level != r_prev_level) && i_level;
    assign click = release_edge
                && (dur < {{(TIME_W-LIMIT_W){1'b0}}, i_cfg.long_limit})
                && (dur < {{(TIME_W-LIMIT_W){1'b0}}, i_cfg.short_limit});

    always_comb begin
        if (gap_rapid > {{(TIME_W-LIMIT_W){1'b0}}, i_cfg.rapid_gap}) begin
            rc_inc = 3'd1;
        end else if (r_rapid_count < RAPID_MAX) begin
            rc_inc = r_rapid_count + 3'd1;
        end else begin
            rc_inc = r_rapid_count;
        end
    end

    assign tog = click && (rc_inc >= i_cfg.rapid_target);
    assign dbl = click && !tog && r_click_pend
              && (gap_first <= {{(TIME_W-LIMIT_W){1'b0}}, i_cfg.double_window});
    // a click just registered as first has zero age, so only an old pending one expires
    assign sgl = !click && r_click_pend
              && (gap_first > {{(TIME_W-LIMIT_W){1'b0}}, i_cfg.double_window});
    assign lng = !i_level && !press && !r_long_rep
              && (dur > {{(TIME_W-LIMIT_W){1'b0}}, i_cfg.long_limit});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level  <= 1'b1;
            r_press_start <= '0;
            r_rapid_count <= '0;
            r_last_rapid  <= '0;
            r_click_pend  <= 1'b0;
            r_first_click <= '0;
            r_long_rep    <= 1'b0;
        end else if (i_step) begin
            r_prev_level <= i_level;
            if (press) begin
                r_press_start <= i_now;
                r_long_rep    <= 1'b0;
            end else if (lng) begin
                r_long_rep <= 1'b1;
            end
            if (click) begin
                r_last_rapid <= i_now;
                if (tog) begin
                    r_rapid_count <= '0;
                    r_click_pend  <= 1'b0;
                end else begin
                    r_rapid_count <= rc_inc;
                    if (!r_click_pend) begin
                        r_click_pend  <= 1'b1;
                        r_first_click <= i_now;
                    end else begin
                        r_click_pend <= 1'b0;
                    end
                end
            end else if (sgl) begin
                r_click_pend <= 1'b0;
            end
        end
    end

    assign o_evt.single_click = sgl;
    assign o_evt.double_click = dbl;
    assign o_evt.rapid_toggle = tog;
    assign o_evt.long_hold    = lng;

    a_tog_dbl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> !(tog && dbl))
        else $error("rapid toggle and double click together");

    a_long_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && lng |=> r_long_rep && !lng)
        else $error("long hold not latched after report");

    a_single_no_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && sgl |=> !r_click_pend)
        else $error("pending click survived single click");

endmodule

FILE: hdl/button_multi_click_classifier_top.sv
// Top level of the button multi-click classifier: input register, core, result register.
// Depends on bmc_pkg, bmc_cfg and bmc_core.
//
// Usage:
//   Slave stream carries one button sample per word: button_level and a
//   free-running millisecond timestamp. Master stream returns exactly one
//   event word per sample: single_click, double_click, rapid_toggle and
//   long_hold flags, mostly all zero.
//   A word accepted at one clock edge sits in the input register; the next
//   edge at which the result register is free (empty or being taken) runs
//   the decision logic and loads the result, which the master stream then
//   offers. Sustained throughput is one word per cycle while the master
//   side takes each result as it is offered.
//   When the master side stalls, the result register holds its word and
//   the input register holds one more; tready then drops until the
//   result is taken, so nothing is lost or repeated.
//   Configuration writes take effect at the next edge and must be made
//   while no word is in flight.
//   Reset (synchronous, active low) empties both registers, restores the
//   default limits and returns the classifier to the released state.
module button_multi_click_classifier_top
    import bmc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [0] button_level, [32:1] now_ms, rest zero
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [0] single, [1] double, [2] rapid, [3] long
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [LIMIT_W-1:0]     i_cfg_wdata
);

    logic              r_in_valid;
    logic              r_in_level;
    logic [TIME_W-1:0] r_in_now;
    logic              r_out_valid;
    t_evt              r_out_evt;

    logic              step;
    logic              s_acc;
    t_cfg              cfg;
    t_evt              evt;

    assign step       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step;
    assign s_acc      = i_s_tvalid && o_s_tready;

    bmc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bmc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_level (r_in_level),
        .i_now   (r_in_now),
        .i_cfg   (cfg),
        .o_evt   (evt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_level <= i_s_tdata[0];
            r_in_now   <= i_s_tdata[TIME_W:1];
        end
        if (step) begin
            r_out_evt <= evt;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W-4){1'b0}}, r_out_evt};

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_m_tready |=> r_in_valid && r_out_valid)
        else $error("word dropped while master side stalled");

endmodule
